FILE: hw/rtl/ttdc_pkg.sv
// ----------------------------------------------------------------------------
// ttdc_pkg: shared constants and types
// Widths, reset values and the arctangent table for the tilt command unit.
// ----------------------------------------------------------------------------
package ttdc_pkg;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int AVG_FRAC_BITS_DEF = 16;
	localparam int ANG_W = 34;
	localparam int VEC_W = 40;
	localparam logic [6:0] THRESH_RESET = 7'd15;

	typedef enum logic [2:0] {
		DIR_STOP = 3'd0,
		DIR_FWD = 3'd1,
		DIR_BACK = 3'd2,
		DIR_RIGHT = 3'd3,
		DIR_LEFT = 3'd4
	} dir_t;

	typedef struct packed {
		logic start;
		logic done;
	} job_t;

	function automatic logic signed [ANG_W-1:0] atan_q16(input logic [4:0] i);
		case (i)
			5'd0: atan_q16 = 34'sd2949120;
			5'd1: atan_q16 = 34'sd1740967;
			5'd2: atan_q16 = 34'sd919879;
			5'd3: atan_q16 = 34'sd466945;
			5'd4: atan_q16 = 34'sd234379;
			5'd5: atan_q16 = 34'sd117304;
			5'd6: atan_q16 = 34'sd58666;
			5'd7: atan_q16 = 34'sd29335;
			5'd8: atan_q16 = 34'sd14668;
			5'd9: atan_q16 = 34'sd7334;
			5'd10: atan_q16 = 34'sd3667;
			5'd11: atan_q16 = 34'sd1833;
			5'd12: atan_q16 = 34'sd917;
			5'd13: atan_q16 = 34'sd458;
			5'd14: atan_q16 = 34'sd229;
			5'd15: atan_q16 = 34'sd115;
			5'd16: atan_q16 = 34'sd57;
			5'd17: atan_q16 = 34'sd29;
			5'd18: atan_q16 = 34'sd14;
			5'd19: atan_q16 = 34'sd7;
			5'd20: atan_q16 = 34'sd4;
			5'd21: atan_q16 = 34'sd2;
			5'd22: atan_q16 = 34'sd1;
			default: atan_q16 = 34'sd0;
		endcase
	endfunction
endpackage

FILE: hw/rtl/ttdc_if.sv
// ----------------------------------------------------------------------------
// ttdc_in_if / ttdc_out_if: valid/ready channels
// Sample channel in, command channel out.
// ----------------------------------------------------------------------------
interface ttdc_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] raw_accel_x;
	logic signed [15:0] raw_accel_y;
	logic signed [15:0] raw_accel_z;
	logic signed [15:0] mag_x;
	logic signed [15:0] mag_y;
	logic signed [15:0] mag_z;
	modport source (output valid, raw_accel_x, raw_accel_y, raw_accel_z, mag_x, mag_y,
		mag_z, input ready);
	modport sink (input valid, raw_accel_x, raw_accel_y, raw_accel_z, mag_x, mag_y,
		mag_z, output ready);
endinterface

interface ttdc_out_if;
	logic valid;
	logic ready;
	logic signed [15:0] filt_accel_x;
	logic signed [15:0] filt_accel_y;
	logic signed [15:0] filt_accel_z;
	logic signed [7:0] pitch_deg;
	logic signed [7:0] roll_deg;
	logic [8:0] heading_deg;
	logic [2:0] direction;
	logic [6:0] speed_pct;
	modport source (output valid, filt_accel_x, filt_accel_y, filt_accel_z, pitch_deg,
		roll_deg, heading_deg, direction, speed_pct, input ready);
	modport sink (input valid, filt_accel_x, filt_accel_y, filt_accel_z, pitch_deg,
		roll_deg, heading_deg, direction, speed_pct, output ready);
endinterface

FILE: hw/rtl/tilt_to_drive_command_unit.sv
// ----------------------------------------------------------------------------
// tilt_to_drive_command_unit: accelerometer tilt to drive command
// Smooths the accelerometer, finds pitch, roll and heading, picks a command.
// ----------------------------------------------------------------------------
// One transaction at a time: a new input is taken only after the previous one has left
//   the decision step. Each root runs start, 32 steps, done; pitch and roll each take a
//   root then a CORDIC angle, and heading a CORDIC angle alone.
// A held result stalls only the next transaction at its decision step.
// Reset: averages and last speed clear to zero, threshold to 15, no result held.
module tilt_to_drive_command_unit
	import ttdc_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
	parameter int AVG_FRAC_BITS = AVG_FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [6:0] cfg_wdata,
	ttdc_in_if.sink in_ch,
	ttdc_out_if.source out_ch
);
	localparam int AW = 16 + AVG_FRAC_BITS;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SQ = 6'b000010,
		ST_CP = 6'b000100,
		ST_CR = 6'b001000,
		ST_CH = 6'b010000,
		ST_DEC = 6'b100000
	} state_t;

	state_t state_q;
	logic [6:0] thr_q;
	logic signed [AW-1:0] avg_x_q, avg_y_q, avg_z_q;
	logic [6:0] last_speed_q;
	logic signed [15:0] fx_q, fy_q, fz_q, mx_q, my_q;
	logic which_q;
	logic signed [31:0] r_pitch_q;
	logic signed [7:0] pitch_q, roll_q;
	logic [8:0] head_q;

	job_t sq_ctl, co_ctl;
	logic sq_busy, sq_done, co_done;
	logic [31:0] sq_root;
	logic signed [ANG_W-1:0] co_angle;
	logic signed [VEC_W-1:0] co_x, co_y;
	logic [63:0] sq_rad;

	// next averages, truncated toward zero for the filtered outputs
	logic signed [AW:0] sx, sy, sz;
	logic signed [AW-1:0] nx, ny, nz;
	assign sx = $signed({in_ch.raw_accel_x, {AVG_FRAC_BITS{1'b0}}}) + avg_x_q;
	assign sy = $signed({in_ch.raw_accel_y, {AVG_FRAC_BITS{1'b0}}}) + avg_y_q;
	assign sz = $signed({in_ch.raw_accel_z, {AVG_FRAC_BITS{1'b0}}}) + avg_z_q;
	assign nx = sx[AW:1];
	assign ny = sy[AW:1];
	assign nz = sz[AW:1];

	function automatic logic signed [15:0] trunc0(input logic signed [AW-1:0] a);
		logic signed [AW-1:0] b;
		b = a + ((a < 0) ? AW'((1 << AVG_FRAC_BITS) - 1) : AW'(0));
		trunc0 = b[AW-1:AVG_FRAC_BITS];
	endfunction

	// squared sum for the current tilt: pitch uses x,z; roll uses y,z
	logic signed [15:0] sa;
	logic signed [31:0] sqa, sqz;
	assign sa = which_q ? fy_q : fx_q;
	assign sqa = sa * sa;
	assign sqz = fz_q * fz_q;
	assign sq_rad = {15'd0, 33'({1'b0, sqa} + {1'b0, sqz}), 16'd0};

	// sign-extend the scaled axes into the CORDIC vector width
	always_comb begin
		if (state_q == ST_CH) begin
			co_x = VEC_W'($signed({mx_q, 8'd0}));
			co_y = VEC_W'($signed({my_q, 8'd0}));
		end else begin
			co_x = VEC_W'($signed({1'b0, r_pitch_q}));
			co_y = VEC_W'($signed({which_q ? fx_q : fy_q, 8'd0}));
		end
	end

	// round half away from zero to whole degrees
	function automatic logic signed [9:0] rnd(input logic signed [ANG_W-1:0] a);
		logic [ANG_W-1:0] m;
		logic [ANG_W-1:0] r;
		m = (a < 0) ? ANG_W'(-a) : ANG_W'(a);
		r = (m + ANG_W'(32768)) >> 16;
		rnd = (a < 0) ? -10'(r) : 10'(r);
	endfunction

	function automatic logic signed [7:0] clamp90(input logic signed [9:0] d);
		if (d > 10'sd90) clamp90 = 8'sd90;
		else if (d < -10'sd90) clamp90 = -8'sd90;
		else clamp90 = 8'(d);
	endfunction

	logic signed [9:0] ang_rnd;
	assign ang_rnd = rnd(co_angle);

	logic start_sq_q, start_co_q;
	assign sq_ctl = '{start: start_sq_q, done: 1'b0};
	assign co_ctl = '{start: start_co_q, done: 1'b0};

	ttdc_isqrt u_sqrt (.clk, .arst_n, .ctl(sq_ctl), .radicand(sq_rad), .busy(sq_busy),
		.done(sq_done), .root(sq_root));

	ttdc_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (.clk, .arst_n, .ctl(co_ctl),
		.x_in(co_x), .y_in(co_y), .done(co_done), .angle(co_angle));

	// direction decision
	logic [6:0] ap, ar;
	logic signed [8:0] t;
	dir_t dir_c;
	logic [6:0] angle_c, target_c, speed_c;
	logic [13:0] prod;
	logic [27:0] quot;
	assign ap = 7'(pitch_q < 0 ? -pitch_q : pitch_q);
	assign ar = 7'(roll_q < 0 ? -roll_q : roll_q);
	assign t = $signed({2'b0, thr_q});
	always_comb begin
		if (pitch_q > t && ar < thr_q) dir_c = DIR_FWD;
		else if (pitch_q < -t && ar < thr_q) dir_c = DIR_BACK;
		else if (roll_q > t && ap < thr_q) dir_c = DIR_RIGHT;
		else if (roll_q < -t && ap < thr_q) dir_c = DIR_LEFT;
		else dir_c = DIR_STOP;
		angle_c = (dir_c == DIR_FWD || dir_c == DIR_BACK) ? ap : ar;
		prod = 14'(angle_c) * 14'd100 + 14'd45;
		// divide by 90 through a reciprocal multiply, exact for prod up to 9045
		quot = 28'(prod) * 28'd11651;
		target_c = 7'(quot >> 20);
		speed_c = 7'((8'(target_c) + 8'(last_speed_q)) >> 1);
	end

	assign in_ch.ready = state_q == ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			thr_q <= THRESH_RESET;
			avg_x_q <= '0;
			avg_y_q <= '0;
			avg_z_q <= '0;
			last_speed_q <= '0;
			out_ch.valid <= 1'b0;
			out_ch.direction <= DIR_STOP;
			out_ch.speed_pct <= '0;
			out_ch.pitch_deg <= '0;
			out_ch.roll_deg <= '0;
			out_ch.heading_deg <= '0;
			out_ch.filt_accel_x <= '0;
			out_ch.filt_accel_y <= '0;
			out_ch.filt_accel_z <= '0;
			pitch_q <= '0;
			roll_q <= '0;
			head_q <= '0;
			start_sq_q <= 1'b0;
			start_co_q <= 1'b0;
			which_q <= 1'b0;
		end else begin
			start_sq_q <= 1'b0;
			start_co_q <= 1'b0;
			if (cfg_we) thr_q <= cfg_wdata;
			// drop valid once the transaction is taken; the decision step reloads it
			if (out_ch.ready && state_q != ST_DEC) out_ch.valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						// take the sample and advance the averages
						avg_x_q <= nx;
						avg_y_q <= ny;
						avg_z_q <= nz;
						which_q <= 1'b0;
						start_sq_q <= 1'b1;
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (sq_done) begin
						start_co_q <= 1'b1;
						state_q <= which_q ? ST_CR : ST_CP;
					end
				end
				ST_CP: begin
					if (co_done) begin
						pitch_q <= clamp90(ang_rnd);
						which_q <= 1'b1;
						start_sq_q <= 1'b1;
						state_q <= ST_SQ;
					end
				end
				ST_CR: begin
					if (co_done) begin
						roll_q <= clamp90(ang_rnd);
						start_co_q <= 1'b1;
						state_q <= ST_CH;
					end
				end
				ST_CH: begin
					if (co_done) begin
						head_q <= 9'(ang_rnd < 0 ? ang_rnd + 10'sd360 : ang_rnd);
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					// hold here while the previous result is still waiting
					if (!out_ch.valid || out_ch.ready) begin
						out_ch.direction <= dir_c;
						out_ch.speed_pct <= (dir_c == DIR_STOP) ? 7'd0 : speed_c;
						if (dir_c != DIR_STOP) last_speed_q <= speed_c;
						out_ch.pitch_deg <= pitch_q;
						out_ch.roll_deg <= roll_q;
						out_ch.heading_deg <= head_q;
						out_ch.filt_accel_x <= fx_q;
						out_ch.filt_accel_y <= fy_q;
						out_ch.filt_accel_z <= fz_q;
						out_ch.valid <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid) begin
			fx_q <= trunc0(nx);
			fy_q <= trunc0(ny);
			fz_q <= trunc0(nz);
			mx_q <= in_ch.mag_x;
			my_q <= in_ch.mag_y;
		end
		if (sq_done) r_pitch_q <= $signed(sq_root);
	end

	// square root and CORDIC are never started together
	assert property (@(posedge clk) disable iff (!arst_n) !(start_sq_q && start_co_q))
		else $error("sqrt and cordic started together");
	// no new transaction while a root is in progress
	assert property (@(posedge clk) disable iff (!arst_n) sq_busy |-> !in_ch.ready)
		else $error("input ready during root");
	// a waiting result stays valid and unchanged
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.direction) &&
		$stable(out_ch.speed_pct) && $stable(out_ch.heading_deg))
		else $error("result changed while waiting");
endmodule

FILE: hw/rtl/ttdc_isqrt.sv
// ----------------------------------------------------------------------------
// ttdc_isqrt: digit-serial integer square root
// Two radicand bits per cycle, one root bit per cycle.
// ----------------------------------------------------------------------------
module ttdc_isqrt
	import ttdc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input job_t ctl,
	input logic [63:0] radicand,
	output logic busy,
	output logic done,
	output logic [31:0] root
);
	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [5:0] cnt_q;
	logic [33:0] trial;
	logic [33:0] rem_sh;

	assign rem_sh = {rem_q[31:0], rad_q[63:62]};
	assign trial = {root_q, 2'b01};
	assign root = root_q;
	assign busy = cnt_q != 6'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 6'd0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (ctl.start) begin
				cnt_q <= 6'd32;
			end else if (cnt_q != 6'd0) begin
				cnt_q <= cnt_q - 6'd1;
				done <= cnt_q == 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rad_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (cnt_q != 6'd0) begin
			rad_q <= {rad_q[61:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q <= rem_sh - trial;
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end
endmodule

FILE: hw/rtl/ttdc_cordic.sv
// ----------------------------------------------------------------------------
// ttdc_cordic: iterative vectoring CORDIC
// One micro-rotation per cycle; angle in degrees, 16 fraction bits.
// ----------------------------------------------------------------------------
module ttdc_cordic
	import ttdc_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input logic clk,
	input logic arst_n,
	input job_t ctl,
	input logic signed [VEC_W-1:0] x_in,
	input logic signed [VEC_W-1:0] y_in,
	output logic done,
	output logic signed [ANG_W-1:0] angle
);
	localparam int CW = $clog2(CORDIC_STEPS + 1);
	logic signed [VEC_W+1:0] x_q, y_q;
	logic signed [ANG_W-1:0] z_q;
	logic [CW-1:0] i_q;
	logic run_q;
	logic signed [VEC_W+1:0] dx, dy;

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign angle = z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (ctl.start) begin
				run_q <= 1'b1;
			end else if (run_q && i_q == CW'(CORDIC_STEPS - 1)) begin
				run_q <= 1'b0;
				done <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			i_q <= '0;
			// a zero vector lands in the else arm and keeps a zero angle
			if (x_in < 0) begin
				x_q <= -(VEC_W+2)'(x_in);
				y_q <= -(VEC_W+2)'(y_in);
				z_q <= (y_in >= 0) ? 34'sd11796480 : -34'sd11796480;
			end else begin
				x_q <= (VEC_W+2)'(x_in);
				y_q <= (VEC_W+2)'(y_in);
				z_q <= '0;
			end
		end else if (run_q) begin
			i_q <= i_q + CW'(1);
			if (x_q == 0 && y_q == 0) begin
				z_q <= z_q;
			end else if (y_q >= 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_q16(5'(i_q));
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_q16(5'(i_q));
			end
		end
	end
endmodule
